>>> rtl/core/cooc_pkg.sv
// Shared types, constants and helper functions for the co-occurrence counter.
package cooc_pkg;

    // Sizing of the count matrix and the open-record buffer.
    localparam int NUM_ITEMS      = 64;
    localparam int MAX_RECORD_LEN = 64;
    localparam int COUNT_WIDTH    = 32;

    // Fixed widths of the transaction fields.
    localparam int IDX_W = 6;
    localparam int OUT_W = 32;

    // Derived memory geometry.
    localparam int MAT_DEPTH = NUM_ITEMS * NUM_ITEMS;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam int BUF_AW    = (MAX_RECORD_LEN > 1) ? $clog2(MAX_RECORD_LEN) : 1;
    localparam int FILL_W    = $clog2(MAX_RECORD_LEN + 1);

    localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

    // Command function codes.
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    // Command transaction.
    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] item_index;
        logic [IDX_W-1:0] column_index;
        logic             end_of_record;
    } in_item_t;

    // Response transaction.
    typedef struct packed {
        logic [OUT_W-1:0] pair_count;
        logic [OUT_W-1:0] record_total;
    } out_item_t;

    // Request from the sequencer to the count store: the address is read every
    // cycle, and inc marks a read-modify-write increment of that entry.
    typedef struct packed {
        logic              inc;
        logic [MAT_AW-1:0] addr;
    } cnt_req_t;

    // True when an index names a tracked item.
    function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
        return 32'(idx) < NUM_ITEMS;
    endfunction

    // Linear address of matrix cell (row, col).
    function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        return MAT_AW'(32'(row) * NUM_ITEMS + 32'(col));
    endfunction

    // Increment that sticks at the all-ones value.
    function automatic count_t sat_inc(input count_t val);
        return (val == '1) ? val : val + COUNT_WIDTH'(1);
    endfunction

    // Clamp a stored count to the response field width.
    function automatic logic [OUT_W-1:0] clamp_out(input count_t val);
        logic [63:0] wide;
        wide = 64'(val);
        return (wide > OUT_MAX) ? '1 : wide[OUT_W-1:0];
    endfunction

endpackage

>>> rtl/core/pairwise_cooccurrence_counter.sv
// Top level of the pairwise co-occurrence counter.
//
//   channel   valid       stall       payload               direction
//   command   cmd_valid   cmd_stall   cmd  (in_item_t)      into the block
//   response  rsp_valid   rsp_stall   rsp  (out_item_t)     out of the block
//
// An add of an item to a record drives the count memory through one
// read-modify-write increment per cycle (diagonal, then both symmetric cells
// of each pair), bypassing the word just written. A read goes through the
// READ, RET and OUT states before it reaches the response register.
// After reset a clearing pass zeroes the 4096-entry count memory, one entry per
// cycle, with cmd_stall high until the pass is done.
// A response waiting under rsp_stall does not block new commands; only a
// second read waits for the response register to free up.
module pairwise_cooccurrence_counter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  cooc_pkg::in_item_t  cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cooc_pkg::out_item_t rsp
);

    cooc_pkg::cnt_req_t  store_req;
    cooc_pkg::count_t    store_data;
    logic                store_busy;
    logic                res_valid;
    cooc_pkg::out_item_t res;
    logic                res_free;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    cooc_pkg::out_item_t rsp_reg;

    cooc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_stall  (cmd_stall),
        .store_busy (store_busy),
        .store_req  (store_req),
        .store_data (store_data),
        .res_valid  (res_valid),
        .res        (res),
        .res_free   (res_free)
    );

    cooc_cnt_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .busy    (store_busy),
        .rd_data (store_data)
    );

    // Response register: free when empty or when its transaction completes.
    assign res_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (res_free)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_free && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> rtl/core/cooc_cnt_store.sv
// Count matrix memory with clearing pass and pipelined saturating increments.
module cooc_cnt_store (
    input  logic               clk,
    input  logic               rst_n,
    input  cooc_pkg::cnt_req_t req,
    output logic               busy,
    output cooc_pkg::count_t   rd_data
);

    cooc_pkg::count_t cnt_mem [cooc_pkg::MAT_DEPTH];

    cooc_pkg::count_t                mem_rdata_reg;
    logic                            clr_busy_reg;
    logic                            clr_busy_next;
    logic [cooc_pkg::MAT_AW-1:0]     clr_addr_reg;
    logic [cooc_pkg::MAT_AW-1:0]     clr_addr_next;
    logic                            pend_reg;
    logic [cooc_pkg::MAT_AW-1:0]     pend_addr_reg;
    logic                            fwd_hit_reg;
    logic                            fwd_hit_next;
    cooc_pkg::count_t                fwd_data_reg;
    logic                            mem_we;
    logic [cooc_pkg::MAT_AW-1:0]     mem_waddr;
    cooc_pkg::count_t                mem_wdata;
    cooc_pkg::count_t                cur_data;

    // Read data of last cycle, bypassed with the write that hit the same entry.
    assign cur_data = fwd_hit_reg ? fwd_data_reg : mem_rdata_reg;
    assign rd_data  = cur_data;
    assign busy     = clr_busy_reg;

    // Write port: the clearing pass after reset, else the increment write-back.
    always_comb
    begin
        mem_we    = clr_busy_reg || pend_reg;
        mem_waddr = clr_busy_reg ? clr_addr_reg : pend_addr_reg;
        mem_wdata = clr_busy_reg ? '0 : cooc_pkg::sat_inc(cur_data);
    end

    // A read issued while the same entry is written sees the old word, so
    // remember the new word for the next cycle.
    assign fwd_hit_next = mem_we && (mem_waddr == req.addr);

    // Clearing pass sequencing.
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + cooc_pkg::MAT_AW'(1);
            if (clr_addr_reg == cooc_pkg::MAT_AW'(cooc_pkg::MAT_DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    // Memory array with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= cnt_mem[req.addr];
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= req.addr;
        fwd_data_reg  <= mem_wdata;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= req.inc && !clr_busy_reg;
            fwd_hit_reg  <= fwd_hit_next;
        end
    end

endmodule

>>> rtl/core/cooc_seq.sv
// Command sequencer: record buffer, pair walk and read handling.
module cooc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cooc_pkg::in_item_t  cmd,
    output logic                cmd_stall,
    input  logic                store_busy,
    output cooc_pkg::cnt_req_t  store_req,
    input  cooc_pkg::count_t    store_data,
    output logic                res_valid,
    output cooc_pkg::out_item_t res,
    input  logic                res_free
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIAG   = 3'd1;
    localparam logic [2:0] S_PAIR_A = 3'd2;
    localparam logic [2:0] S_PAIR_B = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_RET    = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [cooc_pkg::IDX_W-1:0] buf_mem [cooc_pkg::MAX_RECORD_LEN];

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [cooc_pkg::IDX_W-1:0]  idx_reg;
    logic [cooc_pkg::IDX_W-1:0]  idx_next;
    logic [cooc_pkg::IDX_W-1:0]  col_reg;
    logic [cooc_pkg::IDX_W-1:0]  col_next;
    logic [cooc_pkg::IDX_W-1:0]  other_reg;
    logic [cooc_pkg::IDX_W-1:0]  other_next;
    logic [cooc_pkg::IDX_W-1:0]  buf_rdata_reg;
    logic                        last_reg;
    logic                        last_next;
    logic                        live_reg;
    logic                        live_next;
    logic                        rd_ok_reg;
    logic                        rd_ok_next;
    logic [cooc_pkg::FILL_W-1:0] kcnt_reg;
    logic [cooc_pkg::FILL_W-1:0] kcnt_next;
    logic [cooc_pkg::FILL_W-1:0] fill_reg;
    logic [cooc_pkg::FILL_W-1:0] fill_next;
    cooc_pkg::count_t            closed_reg;
    cooc_pkg::count_t            closed_next;
    cooc_pkg::count_t            hold_reg;
    cooc_pkg::count_t            hold_next;
    logic                        buf_we;
    logic                        accept;

    assign cmd_stall = (state_reg != S_IDLE) || store_busy;
    assign accept    = cmd_valid && !cmd_stall;

    // Result seen by the output stage.
    always_comb
    begin
        res_valid        = (state_reg == S_OUT);
        res.pair_count   = rd_ok_reg ? cooc_pkg::clamp_out(hold_reg) : '0;
        res.record_total = cooc_pkg::clamp_out(closed_reg);
    end

    // Next-state and datapath control.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        col_next       = col_reg;
        other_next     = other_reg;
        last_next      = last_reg;
        live_next      = live_reg;
        rd_ok_next     = rd_ok_reg;
        kcnt_next      = kcnt_reg;
        fill_next      = fill_reg;
        closed_next    = closed_reg;
        hold_next      = hold_reg;
        buf_we         = 1'b0;
        store_req.inc  = 1'b0;
        store_req.addr = cooc_pkg::mat_addr(idx_reg, col_reg);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = cmd.item_index;
                    col_next   = cmd.column_index;
                    last_next  = cmd.end_of_record;
                    kcnt_next  = '0;
                    live_next  = cooc_pkg::idx_ok(cmd.item_index);
                    rd_ok_next = cooc_pkg::idx_ok(cmd.item_index)
                                 && cooc_pkg::idx_ok(cmd.column_index);
                    if (cmd.func == cooc_pkg::FUNC_READ)
                    begin
                        state_next = S_READ;
                    end
                    else if (cooc_pkg::idx_ok(cmd.item_index))
                    begin
                        state_next = S_DIAG;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_DIAG:
            begin
                // Diagonal cell; buffer entry zero is fetched meanwhile.
                store_req.inc  = 1'b1;
                store_req.addr = cooc_pkg::mat_addr(idx_reg, idx_reg);
                state_next     = (fill_reg == '0) ? S_FINISH : S_PAIR_A;
            end
            S_PAIR_A:
            begin
                store_req.inc  = 1'b1;
                store_req.addr = cooc_pkg::mat_addr(idx_reg, buf_rdata_reg);
                other_next     = buf_rdata_reg;
                kcnt_next      = kcnt_reg + cooc_pkg::FILL_W'(1);
                state_next     = S_PAIR_B;
            end
            S_PAIR_B:
            begin
                store_req.inc  = 1'b1;
                store_req.addr = cooc_pkg::mat_addr(other_reg, idx_reg);
                state_next     = (kcnt_reg == fill_reg) ? S_FINISH : S_PAIR_A;
            end
            S_FINISH:
            begin
                // Append the item when it is valid and there is room, then close the record if it ends here.
                if (live_reg && (fill_reg < cooc_pkg::FILL_W'(cooc_pkg::MAX_RECORD_LEN)))
                begin
                    buf_we    = 1'b1;
                    fill_next = fill_reg + cooc_pkg::FILL_W'(1);
                end
                if (last_reg)
                begin
                    fill_next   = '0;
                    closed_next = cooc_pkg::sat_inc(closed_reg);
                end
                state_next = S_IDLE;
            end
            S_READ:
            begin
                state_next = S_RET;
            end
            S_RET:
            begin
                hold_next  = store_data;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Record buffer with a registered read port addressed by the walk counter.
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[fill_reg[cooc_pkg::BUF_AW-1:0]] <= idx_reg;
        end
        buf_rdata_reg <= buf_mem[kcnt_reg[cooc_pkg::BUF_AW-1:0]];
    end

    // Transaction payload.
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        col_reg   <= col_next;
        other_reg <= other_next;
        last_reg  <= last_next;
        live_reg  <= live_next;
        rd_ok_reg <= rd_ok_next;
        hold_reg  <= hold_next;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kcnt_reg   <= '0;
            fill_reg   <= '0;
            closed_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kcnt_reg   <= kcnt_next;
            fill_reg   <= fill_next;
            closed_reg <= closed_next;
        end
    end

endmodule

>>> rtl/core/cooc_checker.sv
// Port-level assertions for the co-occurrence counter and their bind.
module cooc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input cooc_pkg::in_item_t  cmd,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input cooc_pkg::out_item_t rsp
);

    logic                       cmd_take;
    logic                       rsp_take;
    logic [cooc_pkg::OUT_W-1:0] last_total_reg;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    // Closed-record total carried by the last response taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= '0;
        end
        else if (rsp_take)
        begin
            last_total_reg <= rsp.record_total;
        end
    end

    // A response held under stall keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // The block works on one command at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> cmd_stall)
        else $error("command accepted while the previous one is in progress");

    // A command taken while no response was pending yields no response before the
    // sequencer has passed through its READ, RET and OUT states.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && !rsp_valid |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
        else $error("response appeared too early");

    // An add never produces a response.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take && (cmd.func == cooc_pkg::FUNC_ADD) && !rsp_valid
        |=> !rsp_valid ##1 !rsp_valid ##1 !rsp_valid ##1 !rsp_valid)
        else $error("add produced a response");

    // The closed-record total seen by successive responses never drops.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_take |-> (rsp.record_total >= last_total_reg))
        else $error("closed-record total dropped between responses");

endmodule

bind pairwise_cooccurrence_counter cooc_checker u_cooc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
